@@ hw/rtl/sirs_pkg.sv @@
`default_nettype none

package sirs_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int MAX_SYMBOLS = 16;
	localparam int RADIX_W     = 5;
	localparam int DIGIT_W     = 4;
	localparam int DIGIT_DEPTH = 32;
	localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int STEP_W      = $clog2(VALUE_BITS);
	localparam int SYM_W       = 8;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 2;

	localparam logic [CFG_IDX_W-1:0] REG_RADIX_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

	localparam logic [SYM_W-1:0] SIGN_BYTE      = 8'h2D;
	localparam logic [SYM_W-1:0] PLUS_BYTE      = 8'h2B;
	localparam logic [SYM_W-1:0] LOW_PRINTABLE  = 8'd32;
	localparam logic [SYM_W-1:0] HIGH_PRINTABLE = 8'd126;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [VALUE_BITS-1:0] dividend;
		logic [RADIX_W-1:0]    divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [VALUE_BITS-1:0] quotient;
		logic [DIGIT_W-1:0]    remainder;
	} div_res_t;

	function automatic logic [SYM_W-1:0] symbol_at(
		input logic [CFG_W-1:0]   lo,
		input logic [CFG_W-1:0]   hi,
		input logic [DIGIT_W-1:0] k
	);
		logic [2*CFG_W-1:0] tbl;
		tbl = {hi, lo};
		return tbl[{k, 3'b000} +: SYM_W];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sirs_divider.sv @@
`default_nettype none

module sirs_divider import sirs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_res_t      res
);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [VALUE_BITS-1:0] work_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [RADIX_W-1:0]    divisor_q;

	logic [DIGIT_W:0]   trial;
	logic               ge;
	logic [DIGIT_W:0]   diff;
	logic [DIGIT_W-1:0] rem_next;
	logic               last_step;

	assign trial     = {rem_q, work_q[VALUE_BITS-1]};
	assign ge        = trial >= divisor_q;
	assign diff      = trial - divisor_q;
	assign rem_next  = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
	assign last_step = (step_q == STEP_W'(VALUE_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && last_step;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q    <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			work_q <= {work_q[VALUE_BITS-2:0], ge};
			rem_q  <= rem_next;
		end
	end

	assign res.done      = done_q;
	assign res.quotient  = work_q;
	assign res.remainder = rem_q;

endmodule

`default_nettype wire

@@ hw/rtl/sirs_table_check.sv @@
`default_nettype none

module sirs_table_check import sirs_pkg::*; (
	input  wire logic [RADIX_W-1:0] radix_count,
	input  wire logic [CFG_W-1:0]   symbols_low,
	input  wire logic [CFG_W-1:0]   symbols_high,
	output logic                    table_ok
);

	logic [SYM_W-1:0] sym [MAX_SYMBOLS];

	always_comb begin
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			sym[i] = symbol_at(symbols_low, symbols_high, DIGIT_W'(i));
		end
	end

	always_comb begin
		logic ok;
		ok = (radix_count >= RADIX_W'(2)) && (radix_count <= RADIX_W'(MAX_SYMBOLS));
		for (int i = 0; i < MAX_SYMBOLS; i++) begin
			if (RADIX_W'(i) < radix_count) begin
				if (sym[i] < LOW_PRINTABLE || sym[i] > HIGH_PRINTABLE) begin
					ok = 1'b0;
				end
				if (sym[i] == SIGN_BYTE || sym[i] == PLUS_BYTE) begin
					ok = 1'b0;
				end
				for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
					if (RADIX_W'(j) < radix_count && sym[j] == sym[i]) begin
						ok = 1'b0;
					end
				end
			end
		end
		table_ok = ok;
	end

endmodule

`default_nettype wire

@@ hw/rtl/signed_integer_to_radix_symbols_unit.sv @@
`default_nettype none
// Each digit comes from the shared shift-subtract divider, which is used for every digit
// of a value; the first symbol is offered only once all digits have been divided.
// One value at a time: a new value is taken only in idle, and its symbols then leave through
// the digit store's registered read, held while the output is stalled.
// Reset: arst_n clears the sequencer, the configuration registers and the output valid.
module signed_integer_to_radix_symbols_unit import sirs_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [VALUE_BITS-1:0] s_tdata,  // value
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [SYM_W-1:0]          m_tdata,   // symbol
	output logic                      m_tlast    // last
);

	logic [RADIX_W-1:0] radix_q;
	logic [CFG_W-1:0]   sym_lo_q;
	logic [CFG_W-1:0]   sym_hi_q;

	state_t state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [DIGIT_W-1:0] rd_q;
	logic [DIGIT_W-1:0] digit_mem [DIGIT_DEPTH];

	logic             m_valid_q;
	logic [SYM_W-1:0] m_data_q;
	logic             m_last_q;

	logic                  table_ok;
	div_req_t              div_req;
	div_res_t              div_res;
	logic                  accept;
	logic                  slot_free;
	logic                  out_load;
	logic                  more_digits;
	logic [VALUE_BITS-1:0] abs_value;
	logic [CNT_W-1:0]      cnt_inc;
	logic [CNT_W-1:0]      cnt_dec;

	sirs_table_check u_check (
		.radix_count (radix_q),
		.symbols_low (sym_lo_q),
		.symbols_high(sym_hi_q),
		.table_ok    (table_ok)
	);

	sirs_divider u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.res   (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= '0;
			sym_lo_q <= '0;
			sym_hi_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RADIX_COUNT:  radix_q  <= cfg_data[RADIX_W-1:0];
				REG_SYMBOLS_LOW:  sym_lo_q <= cfg_data;
				REG_SYMBOLS_HIGH: sym_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept      = s_tvalid && s_tready;
	assign slot_free   = !m_valid_q || m_tready;
	assign out_load    = ((state_q == ST_SIGN) || (state_q == ST_EMIT)) && slot_free;
	assign abs_value   = s_tdata[VALUE_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;
	assign cnt_inc     = cnt_q + 1'b1;
	assign cnt_dec     = cnt_q - 1'b1;
	assign more_digits = (div_res.quotient != '0) && (cnt_inc < CNT_W'(DIGIT_DEPTH));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && table_ok) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_res.done && !more_digits) begin
					state_d = neg_q ? ST_SIGN : ST_READ;
				end
			end
			ST_SIGN: begin
				if (slot_free) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_READ;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = div_res.quotient;
		div_req.divisor  = radix_q;
		unique case (state_q)
			ST_IDLE: begin
				s_tready         = 1'b1;
				div_req.start    = accept && table_ok;
				div_req.dividend = abs_value;
			end
			ST_DIV: begin
				div_req.start = div_res.done && more_digits;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			neg_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && table_ok) begin
						cnt_q <= '0;
						neg_q <= s_tdata[VALUE_BITS-1];
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						cnt_q <= cnt_inc;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						cnt_q <= cnt_dec;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SIGN && slot_free) begin
			m_data_q <= SIGN_BYTE;
			m_last_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			m_data_q <= symbol_at(sym_lo_q, sym_hi_q, rd_q);
			m_last_q <= (cnt_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && div_res.done) begin
			digit_mem[cnt_q[ADDR_W-1:0]] <= div_res.remainder;
		end
		if (state_q == ST_READ) begin
			rd_q <= digit_mem[cnt_dec[ADDR_W-1:0]];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DIGIT_DEPTH))
		else $error("digit count beyond store depth");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == ST_DIV)
		else $error("divider finished outside the division phase");

	a_emit_has_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_READ) |-> cnt_q != '0)
		else $error("emitting with no digit left");
`endif

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
module testbench;
	import sirs_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int TEXT_W = 8 * 33;
	localparam int QUIET_CYCLES = 1200;

	typedef enum logic {ROW_REG, ROW_VALUE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_W-1:0]      data;
		logic [VALUE_BITS-1:0] value;
		logic [TEXT_W-1:0]     text;
	} plan_row_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last;
	} sym_beat_t;

	localparam plan_row_t PLAN [0:35] = '{
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd5, '0},
		'{ROW_REG, REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h3736_3534_3332_3130, 32'd0, '0},
		'{ROW_REG, REG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938, 32'd0, '0},
		'{ROW_REG, REG_RADIX_COUNT, 64'd10, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd0, TEXT_W'("0")},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'h7FFF_FFFF, TEXT_W'("2147483647")},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'h8000_0000, TEXT_W'("-2147483648")},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'hFFFF_FFFF, TEXT_W'("-1")},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd1234567, '0},
		'{ROW_REG, REG_RADIX_COUNT, 64'd16, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'h8000_0000, TEXT_W'("-80000000")},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'hDEAD_BEEF, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'h7FFF_FFFF, TEXT_W'("7FFFFFFF")},
		'{ROW_REG, REG_RADIX_COUNT, 64'd2, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'h8000_0000,
			TEXT_W'({"-1", "0000000000", "0000000000", "0000000000", "0"})},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'h7FFF_FFFF,
			TEXT_W'({"1111111111", "1111111111", "1111111111", "1"})},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd0, TEXT_W'("0")},
		'{ROW_REG, REG_RADIX_COUNT, 64'd1, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_RADIX_COUNT, 64'd31, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F63_6261, 32'd0, '0},
		'{ROW_REG, REG_RADIX_COUNT, 64'd3, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'hFFFF_FFFB, TEXT_W'("-bc")},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F63_2D61, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F2B_6261, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F63_621F, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F63_7F61, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F61_6261, 32'd0, '0},
		'{ROW_VALUE, REG_RADIX_COUNT, 64'd0, 32'd7, '0},
		'{ROW_REG, REG_SYMBOLS_LOW, 64'h002B_2D7F_1F63_6261, 32'd0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VALUE_BITS-1:0] s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [SYM_W-1:0]      m_tdata;
	logic                  m_tlast;

	logic [RADIX_W-1:0] radix_reg = '0;
	logic [CFG_W-1:0]   sym_low_reg = '0;
	logic [CFG_W-1:0]   sym_high_reg = '0;

	sym_beat_t pending_symbols[$];
	int        mismatch_count = 0;
	int        idle_pct = 13;
	int        hold_request = 0;
	bit        quiet_work = 1'b0;

	signed_integer_to_radix_symbols_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#48_000_000;
		$display("** signed_integer_to_radix_symbols_unit: FAILED **");
		$finish;
	end

	function automatic logic [SYM_W-1:0] digit_symbol(input logic [DIGIT_W-1:0] d);
		logic [2*CFG_W-1:0] tbl;
		tbl = {sym_high_reg, sym_low_reg};
		return tbl[8*d +: 8];
	endfunction

	function automatic bit symbols_usable();
		logic [SYM_W-1:0] s;
		if (radix_reg < 2 || radix_reg > MAX_SYMBOLS)
			return 1'b0;
		for (int i = 0; i < radix_reg; i++) begin
			s = digit_symbol(DIGIT_W'(i));
			if (s < LOW_PRINTABLE || s > HIGH_PRINTABLE || s == SIGN_BYTE || s == PLUS_BYTE)
				return 1'b0;
			for (int j = i + 1; j < radix_reg; j++)
				if (digit_symbol(DIGIT_W'(j)) == s)
					return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void predict_symbols(input logic [VALUE_BITS-1:0] value);
		logic [VALUE_BITS-1:0] mag;
		logic [31:0]           base;
		logic [DIGIT_W-1:0]    digits [DIGIT_DEPTH];
		int                    n;
		if (!symbols_usable()) begin
			quiet_work = 1'b1;
			return;
		end
		base = 32'(radix_reg);
		mag = value[VALUE_BITS-1] ? -value : value;
		n = 0;
		do begin
			digits[n] = DIGIT_W'(mag % base);
			mag = mag / base;
			n++;
		end while (mag != 0 && n < DIGIT_DEPTH);
		if (value[VALUE_BITS-1])
			pending_symbols.push_back('{SIGN_BYTE, 1'b0});
		for (int i = n - 1; i >= 0; i--)
			pending_symbols.push_back('{digit_symbol(digits[i]), i == 0});
	endfunction

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_symbols.size() != 0)
			@(posedge clk);
		if (quiet_work)
			repeat (QUIET_CYCLES) @(posedge clk);
		quiet_work = 1'b0;
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_RADIX_COUNT: radix_reg = data[RADIX_W-1:0];
			REG_SYMBOLS_LOW: sym_low_reg = data;
			REG_SYMBOLS_HIGH: sym_high_reg = data;
			default: ;
		endcase
	endtask

	task automatic send_value(input logic [VALUE_BITS-1:0] value, input logic [TEXT_W-1:0] text);
		int top;
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= value;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (text == '0) begin
			predict_symbols(value);
		end else begin
			top = TEXT_W / 8 - 1;
			while (text[8*top +: 8] == 8'd0)
				top--;
			for (int i = top; i >= 0; i--)
				pending_symbols.push_back('{text[8*i +: 8], i == 0});
		end
	endtask

	task automatic make_symbols(input int r, output logic [CFG_W-1:0] lo,
			output logic [CFG_W-1:0] hi);
		logic [2*CFG_W-1:0] tbl;
		logic [SYM_W-1:0]   s;
		bit                 edges;
		bit                 clash;
		tbl = {$urandom, $urandom, $urandom, $urandom};
		edges = ($urandom_range(2) == 0);
		for (int k = 0; k < r; k++) begin
			if (edges && k == 0) begin
				s = LOW_PRINTABLE;
			end else if (edges && k == r - 1) begin
				s = HIGH_PRINTABLE;
			end else begin
				do begin
					s = SYM_W'($urandom_range(32, 126));
					clash = (s == SIGN_BYTE || s == PLUS_BYTE);
					if (edges && (s == LOW_PRINTABLE || s == HIGH_PRINTABLE))
						clash = 1'b1;
					for (int j = 0; j < k; j++)
						if (tbl[8*j +: 8] == s)
							clash = 1'b1;
				end while (clash);
			end
			tbl[8*k +: 8] = s;
		end
		{hi, lo} = tbl;
	endtask

	task automatic spoil_symbols(inout int r, inout logic [CFG_W-1:0] lo,
			inout logic [CFG_W-1:0] hi);
		logic [2*CFG_W-1:0] tbl;
		int                 p;
		int                 q;
		tbl = {hi, lo};
		p = $urandom_range(0, r - 1);
		case ($urandom_range(5))
			0: r = $urandom_range(0, 1);
			1: r = $urandom_range(17, 31);
			2: tbl[8*p +: 8] = SYM_W'($urandom_range(0, 31));
			3: tbl[8*p +: 8] = SYM_W'($urandom_range(127, 255));
			4: tbl[8*p +: 8] = $urandom_range(1) ? SIGN_BYTE : PLUS_BYTE;
			default: begin
				q = (p + $urandom_range(1, r - 1)) % r;
				tbl[8*p +: 8] = tbl[8*q +: 8];
			end
		endcase
		{hi, lo} = tbl;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(input int r);
		logic [VALUE_BITS-1:0] v;
		logic [63:0]           p;
		int                    k;
		case ($urandom_range(9))
			0, 1, 2, 3: v = $urandom;
			4, 5: begin
				v = $urandom_range(0, 300);
				if ($urandom_range(1))
					v = -v;
			end
			6: begin
				case ($urandom_range(4))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = '0;
					3: v = '1;
					default: v = 32'd1;
				endcase
			end
			7: begin
				p = 64'd1;
				k = $urandom_range(1, 31);
				while (k > 0 && p * r <= 64'h8000_0000) begin
					p = p * r;
					k--;
				end
				v = p[31:0] + $urandom_range(0, 2) - 1;
				if ($urandom_range(1))
					v = -v;
			end
			default: begin
				v = $urandom >> $urandom_range(31);
				if ($urandom_range(1))
					v = -v;
			end
		endcase
		return v;
	endfunction

	initial begin
		sym_beat_t beat;
		int        hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready) begin
				if (pending_symbols.size() == 0) begin
					$error("unexpected transfer: symbol %0h last %0b", m_tdata, m_tlast);
					mismatch_count++;
				end else begin
					beat = pending_symbols.pop_front();
					if (m_tdata !== beat.symbol) begin
						$error("symbol: expected %0h, actual %0h", beat.symbol, m_tdata);
						mismatch_count++;
					end
					if (m_tlast !== beat.last) begin
						$error("last: expected %0b, actual %0b", beat.last, m_tlast);
						mismatch_count++;
					end
				end
			end
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	initial begin
		logic [CFG_W-1:0] lo;
		logic [CFG_W-1:0] hi;
		int               r;
		int               phase;
		int               sent;
		int               count;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i]) begin
			if (PLAN[i].kind == ROW_REG)
				write_reg(PLAN[i].index, PLAN[i].data);
			else
				send_value(PLAN[i].value, PLAN[i].text);
		end

		// Random phases: a fresh valid table each time, with an invalid table and a
		// few ignored values thrown in every third phase.
		sent = 0;
		phase = 0;
		while (sent < 190) begin
			case (phase)
				0: r = 2;
				1: r = 16;
				2: r = 10;
				3: r = 8;
				4: r = 3;
				default: r = $urandom_range(2, 16);
			endcase
			if (phase % 3 == 2) begin
				make_symbols(r, lo, hi);
				spoil_symbols(r, lo, hi);
				write_reg(REG_SYMBOLS_LOW, lo);
				write_reg(REG_SYMBOLS_HIGH, hi);
				write_reg(REG_RADIX_COUNT, {$urandom, $urandom} & ~64'h1F | 64'(r));
				repeat (4) send_value($urandom, '0);
				if (r < 2 || r > MAX_SYMBOLS)
					r = $urandom_range(2, 16);
			end
			make_symbols(r, lo, hi);
			write_reg(REG_SYMBOLS_HIGH, hi);
			write_reg(REG_SYMBOLS_LOW, lo);
			write_reg(REG_RADIX_COUNT, {$urandom, $urandom} & ~64'h1F | 64'(r));
			idle_pct = (phase == 3) ? 0 : 13;
			if (phase == 1 || phase == 5)
				hold_request = 2000;
			count = (r == 2) ? $urandom_range(12, 18) : $urandom_range(22, 32);
			repeat (count) begin
				send_value(pick_value(r), '0);
				sent++;
			end
			phase++;
		end
		idle_pct = 13;

		wait_idle();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_symbols.size() == 0)
			$display("** signed_integer_to_radix_symbols_unit: PASSED **");
		else
			$display("** signed_integer_to_radix_symbols_unit: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/sirs_pkg.sv
hw/rtl/sirs_divider.sv
hw/rtl/sirs_table_check.sv
hw/rtl/signed_integer_to_radix_symbols_unit.sv
dv/testbench.sv
